// File: rtl/nad_pkg.sv
`default_nettype none

package nad_pkg;

  localparam int CFG_W     = 6;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COL_COUNT = 2'd1;

  localparam logic [CFG_W-1:0] ROW_COUNT_RESET = 6'd20;
  localparam logic [CFG_W-1:0] COL_COUNT_RESET = 6'd30;

  localparam logic [7:0] CHAR_ZERO = 8'h30;
  localparam logic [7:0] CHAR_NINE = 8'h39;

  // Pixel under correction and its four neighbors, with presence flags.
  typedef struct packed {
    logic [3:0] center;
    logic [3:0] left;
    logic [3:0] right;
    logic [3:0] up;
    logic [3:0] down;
    logic       has_left;
    logic       has_right;
    logic       has_up;
    logic       has_down;
  } nbr_t;

  function automatic logic [7:0] glyph_of(input logic [3:0] lv);
    logic [7:0] g;
    case (lv)
      4'd0:    g = 8'h20;  // ' '
      4'd1:    g = 8'h2E;  // '.'
      4'd2:    g = 8'h27;  // '\''
      4'd3:    g = 8'h3A;  // ':'
      4'd4:    g = 8'h7E;  // '~'
      4'd5:    g = 8'h2A;  // '*'
      4'd6:    g = 8'h3D;  // '='
      4'd7:    g = 8'h24;  // '$'
      4'd8:    g = 8'h25;  // '%'
      default: g = 8'h23;  // '#'
    endcase
    return g;
  endfunction

endpackage

`default_nettype wire

// File: rtl/nad_settle.sv
`default_nettype none

// Replaces the center by the rounded neighbor average when any present
// neighbor differs from it by more than one.
module nad_settle (
  input  nad_pkg::nbr_t nbr,
  output logic [3:0]    level
);

  function automatic logic far_apart(input logic [3:0] a, input logic [3:0] b);
    logic [3:0] d;
    d = (a > b) ? (a - b) : (b - a);
    return d > 4'd1;
  endfunction

  logic       odd;
  logic [5:0] sum;
  logic [2:0] n;
  logic [6:0] num3;
  logic [12:0] prod3;
  logic [5:0] avg2;
  logic [5:0] avg4;

  always_comb begin
    odd = (nbr.has_left  && far_apart(nbr.center, nbr.left))  ||
          (nbr.has_right && far_apart(nbr.center, nbr.right)) ||
          (nbr.has_up    && far_apart(nbr.center, nbr.up))    ||
          (nbr.has_down  && far_apart(nbr.center, nbr.down));
    sum = (nbr.has_left  ? {2'b00, nbr.left}  : 6'd0) +
          (nbr.has_right ? {2'b00, nbr.right} : 6'd0) +
          (nbr.has_up    ? {2'b00, nbr.up}    : 6'd0) +
          (nbr.has_down  ? {2'b00, nbr.down}  : 6'd0);
    n = 3'({2'b00, nbr.has_left}) + 3'({2'b00, nbr.has_right}) +
        3'({2'b00, nbr.has_up}) + 3'({2'b00, nbr.has_down});
    // round half up: (2*sum + n) / (2*n)
    avg2  = (sum + 6'd1) >> 1;
    avg4  = (sum + 6'd2) >> 2;
    num3  = {sum, 1'b0} + 7'd3;
    prod3 = 13'(num3) * 13'd43;  // x/6 as x*43/256, exact for x < 64
    level = nbr.center;
    if (odd) begin
      case (n)
        3'd2:    level = avg2[3:0];
        3'd3:    level = prod3[11:8];
        3'd4:    level = avg4[3:0];
        default: level = nbr.center;
      endcase
    end
  end

endmodule

`default_nettype wire

// File: rtl/neighbor_average_despeckle.sv
`default_nettype none

// Channel   Direction  Handshake              Payload
// cfg       in         cfg_write              cfg_index, cfg_data
// pixel     in         in_valid / in_ready    pixel_char
// result    out        out_valid / out_ready  level, glyph, end_of_row, end_of_frame
//
// A digit goes through the transfer cycle, in which the line memories are
// read at the current column, then the correct/write-back cycle. A non-digit
// byte is accepted and causes nothing.
// The last row is flushed after the final pixel, one column at a time
// (registered memory read, then correct), in_ready low meanwhile.
// rst is synchronous; it clears position, loads the default sizes and empties
// the output register.
// The line memories are not cleared: each entry is written before use.
// Past the first row a full result register holds the correct cycle and in_ready
// until the waiting transfer completes; in_ready is also low during cfg_write.
module neighbor_average_despeckle #(
  parameter int MAX_COLS = 32,
  parameter int MAX_ROWS = 32
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write,
  input  logic [nad_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [nad_pkg::CFG_W-1:0]       cfg_data,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [7:0]                      pixel_char,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [3:0]                      level,
  output logic [7:0]                      glyph,
  output logic                            end_of_row,
  output logic                            end_of_frame
);

  localparam int CW  = $clog2(MAX_COLS);
  localparam int RW  = $clog2(MAX_ROWS);
  localparam int CSW = (CW + 1 > nad_pkg::CFG_W) ? CW + 1 : nad_pkg::CFG_W;
  localparam int RSW = (RW + 1 > nad_pkg::CFG_W) ? RW + 1 : nad_pkg::CFG_W;

  typedef enum logic [1:0] {
    S_IDLE,   // waiting for a pixel
    S_CALC,   // line data valid: correct the pixel above, write back
    S_FREAD,  // flush: line memories being read
    S_FCALC   // flush: correct one pixel of the last row
  } state_t;

  state_t state;

  logic [nad_pkg::CFG_W-1:0] row_count;
  logic [nad_pkg::CFG_W-1:0] col_count;
  logic [RW-1:0]             row_pos;
  logic [CW-1:0]             col_pos;
  logic [3:0]                left_fixed;
  logic [3:0]                pix;

  // line memories: raw row above, corrected row above
  logic [3:0] raw_mem   [MAX_COLS];
  logic [3:0] fixed_mem [MAX_COLS];
  logic [3:0] raw_c;
  logic [3:0] raw_r;
  logic [3:0] fixed_u;

  logic [CSW-1:0] col_ext;
  logic [RSW-1:0] row_ext;
  logic [CW:0]    cols_eff;
  logic [RW:0]    rows_eff;
  logic [CW-1:0]  col_nxt;
  logic           last_col;
  logic           last_row;
  logic           flushing;
  logic           is_digit;
  logic           out_free;
  logic           calc_go;
  logic           mem_we;
  logic           out_load;

  nad_pkg::nbr_t nbr;
  logic [3:0]    lv;

  // frame size clamped to 2..MAX
  assign col_ext  = CSW'(col_count);
  assign row_ext  = RSW'(row_count);
  assign cols_eff = (col_ext < CSW'(2)) ? (CW + 1)'(2) :
                    (col_ext > CSW'(MAX_COLS)) ? (CW + 1)'(MAX_COLS) : col_ext[CW:0];
  assign rows_eff = (row_ext < RSW'(2)) ? (RW + 1)'(2) :
                    (row_ext > RSW'(MAX_ROWS)) ? (RW + 1)'(MAX_ROWS) : row_ext[RW:0];

  assign col_nxt  = col_pos + CW'(1);
  assign last_col = ({1'b0, col_pos} + (CW + 1)'(1)) == cols_eff;
  assign last_row = ({1'b0, row_pos} + (RW + 1)'(1)) == rows_eff;
  assign flushing = (state == S_FREAD) || (state == S_FCALC);
  assign is_digit = (pixel_char >= nad_pkg::CHAR_ZERO) && (pixel_char <= nad_pkg::CHAR_NINE);
  // a write to a known register restarts the frame; no pixel is taken during any write
  assign in_ready = (state == S_IDLE) && !cfg_write;
  assign out_free = !out_valid || out_ready;
  // first row only stores; other rows need room in the result register
  assign calc_go  = (row_pos == '0) || out_free;
  assign mem_we   = (state == S_CALC) && calc_go;
  // result register loads a corrected pixel this cycle
  assign out_load = !cfg_write &&
                    (((state == S_CALC) && calc_go && (row_pos != '0)) ||
                     ((state == S_FCALC) && out_free));

  // During the flush col_pos walks the last row; the down neighbor is absent.
  always_comb begin
    nbr.center    = raw_c;
    nbr.left      = left_fixed;
    nbr.right     = raw_r;
    nbr.up        = fixed_u;
    nbr.down      = pix;
    nbr.has_left  = (col_pos != '0);
    nbr.has_right = !last_col;
    nbr.has_up    = flushing || (row_pos > RW'(1));
    nbr.has_down  = !flushing;
  end

  nad_settle u_settle (
    .nbr   (nbr),
    .level (lv)
  );

  // Reads follow col_pos every cycle; a write always lands before the read that
  // needs it, so no forwarding is required.
  always_ff @(posedge clk) begin
    raw_c   <= raw_mem[col_pos];
    raw_r   <= raw_mem[col_nxt];
    fixed_u <= fixed_mem[col_pos];
    if (mem_we) begin
      raw_mem[col_pos] <= pix;
      if (row_pos != '0) begin
        fixed_mem[col_pos] <= lv;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      row_count  <= nad_pkg::ROW_COUNT_RESET;
      col_count  <= nad_pkg::COL_COUNT_RESET;
      row_pos    <= '0;
      col_pos    <= '0;
      left_fixed <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (cfg_write) begin
        // any known register restarts the frame
        case (cfg_index)
          nad_pkg::REG_ROW_COUNT: begin
            row_count  <= cfg_data;
            row_pos    <= '0;
            col_pos    <= '0;
            left_fixed <= '0;
            state      <= S_IDLE;
          end
          nad_pkg::REG_COL_COUNT: begin
            col_count  <= cfg_data;
            row_pos    <= '0;
            col_pos    <= '0;
            left_fixed <= '0;
            state      <= S_IDLE;
          end
          default: ;
        endcase
      end else begin
        case (state)
          S_IDLE: begin
            if (in_valid && is_digit) begin
              pix   <= 4'(pixel_char - nad_pkg::CHAR_ZERO);
              state <= S_CALC;
            end
          end
          S_CALC: begin
            if (calc_go) begin
              if (row_pos != '0) begin
                level        <= lv;
                glyph        <= nad_pkg::glyph_of(lv);
                end_of_row   <= last_col;
                end_of_frame <= 1'b0;
              end
              if (!last_col) begin
                col_pos <= col_nxt;
                if (row_pos != '0) begin
                  left_fixed <= lv;
                end
                state   <= S_IDLE;
              end else begin
                col_pos    <= '0;
                left_fixed <= '0;
                if (!last_row) begin
                  row_pos <= row_pos + RW'(1);
                  state   <= S_IDLE;
                end else begin
                  row_pos <= '0;
                  state   <= S_FREAD;
                end
              end
            end
          end
          S_FREAD: begin
            state <= S_FCALC;
          end
          S_FCALC: begin
            if (out_free) begin
              level        <= lv;
              glyph        <= nad_pkg::glyph_of(lv);
              end_of_row   <= last_col;
              end_of_frame <= last_col;
              if (last_col) begin
                col_pos    <= '0;
                left_fixed <= '0;
                state      <= S_IDLE;
              end else begin
                col_pos    <= col_nxt;
                left_fixed <= lv;
                state      <= S_FREAD;
              end
            end
          end
          default: state <= S_IDLE;
        endcase
      end
    end
  end

  // position stays inside the clamped frame
  a_col_in_frame: assert property (@(posedge clk) disable iff (rst)
    ({1'b0, col_pos} < cols_eff) && ({1'b0, row_pos} < rows_eff))
    else $error("frame position out of range");

  a_eof_is_eor: assert property (@(posedge clk) disable iff (rst)
    (out_valid && end_of_frame) |-> end_of_row)
    else $error("end_of_frame without end_of_row");

  // completing the flush returns to a clean start of frame
  a_flush_done: assert property (@(posedge clk) disable iff (rst)
    (state == S_FCALC && out_free && last_col && !cfg_write) |=>
      (state == S_IDLE && col_pos == '0 && row_pos == '0 && left_fixed == '0))
    else $error("flush did not restart the frame");

  // a corrected pixel follows each write of a later row unless cfg_write is high
  a_emit_on_write: assert property (@(posedge clk) disable iff (rst)
    (mem_we && row_pos != '0 && !cfg_write) |=> out_valid)
    else $error("corrected pixel not delivered");

endmodule

`default_nettype wire

// File: dv/tb.sv
`timescale 1ns / 1ps

module tb;

  // Largest frame side the block supports; register values are clamped to 2..MAX_DIM.
  localparam int MAX_DIM = 32;
  // Register indexes past the end of the map; writes there must be dropped.
  localparam logic [nad_pkg::CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [nad_pkg::CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;
  // Cycles with no transfer on either channel before the run is declared hung.
  localparam int IDLE_LIMIT = 5000;
  // Margin that lets the block finish a result-free pixel.
  localparam int SETTLE_CYCLES = 8;
  // Glyph per level: byte k of this constant is the glyph of level k.
  localparam logic [79:0] GLYPH_ROM = "#%$=*~:'. ";

  typedef struct packed {
    logic [3:0] level;
    logic [7:0] glyph;
    logic       row_end;
    logic       frame_end;
  } pixel_out_t;

  logic                          clk;
  logic                          rst;
  logic                          cfg_write;
  logic [nad_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [nad_pkg::CFG_W-1:0]     cfg_data;
  logic                          in_valid;
  logic                          in_ready;
  logic [7:0]                    pixel_char;
  logic                          out_valid;
  logic                          out_ready;
  logic [3:0]                    level;
  logic [7:0]                    glyph;
  logic                          end_of_row;
  logic                          end_of_frame;

  // Bytes waiting to be sent, and corrected pixels the block still owes us.
  logic [7:0] pixel_backlog [$];
  pixel_out_t expected_px [$];

  // Idle rates in percent, changed only between phases.
  int send_idle_pct;
  int recv_stall_pct;
  int mismatches;
  int quiet_cycles;

  // Shadow of the block: frame size registers, line buffers and position.
  logic [nad_pkg::CFG_W-1:0] rows_reg;
  logic [nad_pkg::CFG_W-1:0] cols_reg;
  logic [3:0]                raw_row [MAX_DIM];
  logic [3:0]                fixed_row [MAX_DIM];
  logic [3:0]                left_lv;
  int                        row_at;
  int                        col_at;

  neighbor_average_despeckle u_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .pixel_char   (pixel_char),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .level        (level),
    .glyph        (glyph),
    .end_of_row   (end_of_row),
    .end_of_frame (end_of_frame)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Despeckle predictor
  // ---------------------------------------------------------------------------

  function automatic int clamp_dim(input logic [nad_pkg::CFG_W-1:0] v);
    if (v < 2) return 2;
    if (v > MAX_DIM) return MAX_DIM;
    return int'(v);
  endfunction

  // Keep the center unless it is more than 1 away from some neighbor; then
  // take the neighbor mean, rounded half up.
  function automatic logic [3:0] smooth(input logic [3:0] ctr, input logic [15:0] nbs,
                                        input int n);
    int sum;
    int k;
    int cv;
    int nv;
    logic outlier;
    sum = 0;
    outlier = 1'b0;
    cv = int'(ctr);
    for (k = 0; k < n; k++) begin
      nv = int'(nbs[4*k +: 4]);
      if (cv > nv + 1 || nv > cv + 1) outlier = 1'b1;
      sum += nv;
    end
    if (!outlier) return ctr;
    return 4'((2 * sum + n) / (2 * n));
  endfunction

  function automatic void owe_pixel(input logic [3:0] lv, input logic eor, input logic eof);
    pixel_out_t px;
    px.level     = lv;
    px.glyph     = GLYPH_ROM[8*lv +: 8];
    px.row_end   = eor;
    px.frame_end = eof;
    expected_px.push_back(px);
  endfunction

  function automatic void restart_frame();
    row_at  = 0;
    col_at  = 0;
    left_lv = 4'd0;
  endfunction

  // One accepted byte: store it, correct the pixel above it, and flush the
  // last row once the frame is complete.
  task automatic despeckle_pixel(input logic [7:0] ch);
    int rows;
    int cols;
    int r;
    int c;
    int n;
    int k;
    logic [3:0] v;
    logic [3:0] lv;
    logic [3:0] prev;
    logic [15:0] nbs;
    if (ch < nad_pkg::CHAR_ZERO || ch > nad_pkg::CHAR_NINE) return;
    rows = clamp_dim(rows_reg);
    cols = clamp_dim(cols_reg);
    v = 4'(ch - nad_pkg::CHAR_ZERO);
    if (row_at >= rows || col_at >= cols) restart_frame();
    r = row_at;
    c = col_at;

    if (r == 0) begin
      raw_row[c] = v;
    end else begin
      // This pixel is the down neighbor of (r-1, c).
      n = 0;
      nbs = '0;
      if (c > 0) begin
        nbs = {nbs[11:0], left_lv};
        n++;
      end
      if (c + 1 < cols) begin
        nbs = {nbs[11:0], raw_row[c+1]};
        n++;
      end
      if (r > 1) begin
        nbs = {nbs[11:0], fixed_row[c]};
        n++;
      end
      nbs = {nbs[11:0], v};
      n++;
      lv = smooth(raw_row[c], nbs, n);
      owe_pixel(lv, c + 1 == cols, 1'b0);
      fixed_row[c] = lv;
      raw_row[c]   = v;
      left_lv      = lv;
    end

    if (c + 1 < cols) begin
      col_at = c + 1;
      return;
    end
    col_at  = 0;
    left_lv = 4'd0;
    if (r + 1 < rows) begin
      row_at = r + 1;
      return;
    end

    // Final pixel: last row goes out with no down neighbor.
    prev = 4'd0;
    for (k = 0; k < cols; k++) begin
      n = 0;
      nbs = '0;
      if (k > 0) begin
        nbs = {nbs[11:0], prev};
        n++;
      end
      if (k + 1 < cols) begin
        nbs = {nbs[11:0], raw_row[k+1]};
        n++;
      end
      nbs = {nbs[11:0], fixed_row[k]};
      n++;
      lv = smooth(raw_row[k], nbs, n);
      owe_pixel(lv, k + 1 == cols, k + 1 == cols);
      prev = lv;
    end
    restart_frame();
  endtask

  // ---------------------------------------------------------------------------
  // Driver, receiver, monitor, watchdog
  // ---------------------------------------------------------------------------

  // Pixel driver: a new byte only once the previous transfer is done.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (pixel_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_valid   <= 1'b1;
        pixel_char <= pixel_backlog.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result receiver back-pressure.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Monitor: compare result transfers, then feed the predictor with register
  // writes and pixel transfers seen at this edge.
  always @(posedge clk) begin
    pixel_out_t want;
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (expected_px.size() == 0) begin
          $error("unexpected result: level %0d glyph %h eor %0b eof %0b",
                 level, glyph, end_of_row, end_of_frame);
          mismatches++;
        end else begin
          want = expected_px.pop_front();
          if (level !== want.level) begin
            $error("level: expected %0d, got %0d", want.level, level);
            mismatches++;
          end
          if (glyph !== want.glyph) begin
            $error("glyph: expected %h, got %h", want.glyph, glyph);
            mismatches++;
          end
          if (end_of_row !== want.row_end) begin
            $error("end_of_row: expected %0b, got %0b", want.row_end, end_of_row);
            mismatches++;
          end
          if (end_of_frame !== want.frame_end) begin
            $error("end_of_frame: expected %0b, got %0b", want.frame_end, end_of_frame);
            mismatches++;
          end
        end
      end
      if (cfg_write) begin
        case (cfg_index)
          nad_pkg::REG_ROW_COUNT: begin
            rows_reg = cfg_data;
            restart_frame();
          end
          nad_pkg::REG_COL_COUNT: begin
            cols_reg = cfg_data;
            restart_frame();
          end
          default: ;
        endcase
      end
      if (in_valid && in_ready) despeckle_pixel(pixel_char);
    end
  end

  // Hang detector: any transfer restarts the count.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= IDLE_LIMIT) begin
      $display("tb: done, errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  // Returns at a falling edge once every byte is sent, every result is in and
  // the block has had time to finish a result-free pixel.
  task automatic wait_idle();
    do @(negedge clk);
    while (pixel_backlog.size() != 0 || in_valid || expected_px.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Single-cycle register write; returns at a falling edge.
  task automatic write_reg(input logic [nad_pkg::CFG_IDX_W-1:0] idx,
                           input logic [nad_pkg::CFG_W-1:0] val);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_write <= 1'b0;
    @(negedge clk);
  endtask

  task automatic queue_text(input string s);
    int i;
    for (i = 0; i < s.len(); i++) pixel_backlog.push_back(s[i]);
  endtask

  function automatic logic [7:0] noise_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(255));
    while (b >= nad_pkg::CHAR_ZERO && b <= nad_pkg::CHAR_NINE);
    return b;
  endfunction

  initial begin
    int p;
    int f;
    int d;
    int rows_w;
    int cols_w;
    int frames;
    int frame_px;
    int base;
    int val;
    int roll;

    rst        = 1'b1;
    cfg_write  = 1'b0;
    cfg_index  = '0;
    cfg_data   = '0;
    in_valid   = 1'b0;
    pixel_char = 8'h00;
    out_ready  = 1'b0;
    mismatches = 0;
    quiet_cycles = 0;
    rows_reg   = nad_pkg::ROW_COUNT_RESET;
    cols_reg   = nad_pkg::COL_COUNT_RESET;
    restart_frame();
    send_idle_pct  = 6;
    recv_stall_pct = 75;

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Directed: smallest frame, digit boundaries, ignored bytes, back-to-back
    // frames, and a partial frame dropped by a register write.
    write_reg(nad_pkg::REG_ROW_COUNT, 6'd2);
    write_reg(nad_pkg::REG_COL_COUNT, 6'd2);
    queue_text("90");
    pixel_backlog.push_back(8'h00);
    queue_text("0");
    pixel_backlog.push_back(8'hFF);
    queue_text("9");
    queue_text("/5:5");
    pixel_backlog.push_back(8'h80);
    queue_text("1");
    pixel_backlog.push_back(8'h7F);
    queue_text("5");
    queue_text("347");
    wait_idle();
    write_reg(nad_pkg::REG_COL_COUNT, 6'd2);
    queue_text("2822");
    wait_idle();

    // Random phases: frame shapes include the clamped extremes on both sides.
    for (p = 0; p < 7; p++) begin
      case (p)
        0:       begin rows_w = 2;  cols_w = 2;  frames = 4; frame_px = 4;  end
        1:       begin rows_w = 0;  cols_w = 63; frames = 1; frame_px = 64; end
        2:       begin rows_w = 5;  cols_w = 7;  frames = 1; frame_px = 35; end
        3:       begin rows_w = 33; cols_w = 1;  frames = 1; frame_px = 64; end
        4:       begin rows_w = 1;  cols_w = 0;  frames = 4; frame_px = 4;  end
        5:       begin rows_w = 3;  cols_w = 3;  frames = 2; frame_px = 9;  end
        default: begin rows_w = 4;  cols_w = 4;  frames = 2; frame_px = 16; end
      endcase
      // Fast sender / busy receiver, then the reverse, then full rate.
      if (p < 3) begin
        send_idle_pct  = 6;
        recv_stall_pct = 75;
      end else if (p < 5) begin
        send_idle_pct  = 75;
        recv_stall_pct = 6;
      end else begin
        send_idle_pct  = 0;
        recv_stall_pct = 0;
      end
      write_reg(nad_pkg::REG_ROW_COUNT, 6'(rows_w));
      write_reg(nad_pkg::REG_COL_COUNT, 6'(cols_w));
      write_reg(REG_SPARE_A, 6'($urandom_range(63)));
      write_reg(REG_SPARE_B, 6'($urandom_range(63)));

      for (f = 0; f < frames; f++) begin
        // Smooth field around a drifting base with occasional speckles.
        base = $urandom_range(9);
        for (d = 0; d < frame_px; d++) begin
          // Sender holds mid-frame until the block has caught up.
          if (p == 2 && d == 17) wait_idle();
          if ($urandom_range(99) < 12) pixel_backlog.push_back(noise_byte());
          roll = $urandom_range(99);
          if (roll < 20) begin
            val = $urandom_range(9);
          end else begin
            val = base + $urandom_range(2) - 1;
            if (val < 0) val = 0;
            if (val > 9) val = 9;
            if (roll >= 95) base = val;
          end
          pixel_backlog.push_back(nad_pkg::CHAR_ZERO + 8'(val));
        end
      end
      wait_idle();
    end

    // Let any stray result show up before the verdict.
    repeat (4 * MAX_DIM) @(negedge clk);
    if (mismatches == 0 && expected_px.size() == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule
